/* rtl/pmiw_pkg.sv */
// ----------------------------------------------------------------------------
// pmiw_pkg
// Shared constants and types for the periodic minimum-image / wrap unit.
// ----------------------------------------------------------------------------
package pmiw_pkg;

  // Q16.16 vector component width and number of axes
  localparam int DATA_W   = 32;
  localparam int NUM_AXES = 3;

  // Packed matrix row register width (three entries)
  localparam int ROW_W = 63;

  // Defaults for the top-level parameters
  localparam int DEF_POS_FRAC_BITS = 16;
  localparam int DEF_COEF_WIDTH    = 21;

  // Configuration register map
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_ROW0 = 3'd0,
    REG_CELL_ROW1 = 3'd1,
    REG_CELL_ROW2 = 3'd2,
    REG_INV_ROW0  = 3'd3,
    REG_INV_ROW1  = 3'd4,
    REG_INV_ROW2  = 3'd5,
    REG_PER_MASK  = 3'd6
  } cfg_idx_t;

  // Saturation limits
  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Per-lane reduction control
  typedef struct packed {
    logic wrap;      // 1: floor (wrap), 0: round half away from zero
    logic periodic;  // axis is periodic
  } frac_ctl_t;

endpackage

/* rtl/pmiw_frac_lane.sv */
// ----------------------------------------------------------------------------
// pmiw_frac_lane
// One fractional-coordinate lane: inverse row dot product, then reduction
// to the fractional distance (nearest image) or the fractional part (wrap).
// ----------------------------------------------------------------------------
module pmiw_frac_lane #(
  parameter int POS_FRAC_BITS = pmiw_pkg::DEF_POS_FRAC_BITS,
  parameter int COEF_WIDTH    = pmiw_pkg::DEF_COEF_WIDTH
) (
  input  logic                                              clk,
  input  logic [pmiw_pkg::ROW_W-1:0]                        inv_row,
  input  logic [pmiw_pkg::NUM_AXES-1:0][pmiw_pkg::DATA_W-1:0] pos_i,
  input  pmiw_pkg::frac_ctl_t                               ctl_i,
  output logic [COEF_WIDTH+33:0]                            frac_o
);

  localparam int INV_FRAC = COEF_WIDTH - 2;
  localparam int F        = POS_FRAC_BITS + INV_FRAC;   // fraction bits of s
  localparam int PW       = COEF_WIDTH + pmiw_pkg::DATA_W;
  localparam int SW       = COEF_WIDTH + 34;

  logic signed [PW-1:0]  prod_r [pmiw_pkg::NUM_AXES];
  pmiw_pkg::frac_ctl_t   ctl_r;
  logic signed [SW-1:0]  acc;
  logic [SW-1:0]         frac_nxt;
  logic [SW-1:0]         frac_r;
  logic                  round_up;

  // stage 1: products
  always_ff @(posedge clk) begin
    for (int j = 0; j < pmiw_pkg::NUM_AXES; j++) begin
      prod_r[j] <= $signed(inv_row[j*COEF_WIDTH +: COEF_WIDTH]) * $signed(pos_i[j]);
    end
    ctl_r <= ctl_i;
  end

  // stage 2: sum and reduce
  always_comb begin
    acc = SW'(prod_r[0]) + SW'(prod_r[1]) + SW'(prod_r[2]);
    // fraction above one half; an exact half only rounds up for non-negative
    round_up = acc[SW-1] ? (acc[F-1] && (|acc[F-2:0])) : acc[F-1];
    if (!ctl_r.periodic) begin
      frac_nxt = acc;
    end else if (ctl_r.wrap || !round_up) begin
      frac_nxt = {{(SW-F){1'b0}}, acc[F-1:0]};
    end else begin
      // frac - 1: low bits unchanged, upper bits all ones
      frac_nxt = {{(SW-F){1'b1}}, acc[F-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    frac_r <= frac_nxt;
  end

  assign frac_o = frac_r;

endmodule

/* rtl/pmiw_cart_lane.sv */
// ----------------------------------------------------------------------------
// pmiw_cart_lane
// One Cartesian output lane: cell row times the reduced fractional vector,
// split into high/low partial products, rounded half up and saturated.
// ----------------------------------------------------------------------------
module pmiw_cart_lane #(
  parameter int COEF_WIDTH = pmiw_pkg::DEF_COEF_WIDTH
) (
  input  logic                                          clk,
  input  logic [pmiw_pkg::ROW_W-1:0]                    cell_row,
  input  logic [pmiw_pkg::NUM_AXES-1:0][COEF_WIDTH+33:0] frac_i,
  output logic [pmiw_pkg::DATA_W-1:0]                   res_o
);

  localparam int CELL_FRAC = COEF_WIDTH / 2;
  localparam int INV_FRAC  = COEF_WIDTH - 2;
  localparam int SH        = INV_FRAC + CELL_FRAC;
  localparam int SW        = COEF_WIDTH + 34;
  localparam int HW        = SW - 32;                  // high slice of s
  localparam int PHW       = COEF_WIDTH + HW;
  localparam int PLW       = COEF_WIDTH + 33;
  localparam int HSW       = PHW + 2;
  localparam int LSW       = PLW + 3;
  localparam int TW        = 2 * COEF_WIDTH + 37;
  localparam int DW        = pmiw_pkg::DATA_W;
  localparam logic signed [LSW-1:0] RND = LSW'(64'd1 << (SH - 1));

  logic signed [PHW-1:0] prod_hi_r [pmiw_pkg::NUM_AXES];
  logic signed [PLW-1:0] prod_lo_r [pmiw_pkg::NUM_AXES];
  logic signed [HSW-1:0] hi_sum_r;
  logic signed [LSW-1:0] lo_sum_r;
  logic signed [TW-1:0]  tot;
  logic [TW-SH-DW:0]     top_bits;
  logic [DW-1:0]         res_nxt;
  logic [DW-1:0]         res_r;

  // stage 3: partial products on the high and low words of s
  always_ff @(posedge clk) begin
    for (int j = 0; j < pmiw_pkg::NUM_AXES; j++) begin
      prod_hi_r[j] <= $signed(cell_row[j*COEF_WIDTH +: COEF_WIDTH])
                      * $signed(frac_i[j][SW-1:32]);
      prod_lo_r[j] <= $signed(cell_row[j*COEF_WIDTH +: COEF_WIDTH])
                      * $signed({1'b0, frac_i[j][31:0]});
    end
  end

  // stage 4: partial sums, rounding constant folded into the low sum
  always_ff @(posedge clk) begin
    hi_sum_r <= HSW'(prod_hi_r[0]) + HSW'(prod_hi_r[1]) + HSW'(prod_hi_r[2]);
    lo_sum_r <= LSW'(prod_lo_r[0]) + LSW'(prod_lo_r[1]) + LSW'(prod_lo_r[2]) + RND;
  end

  // stage 5: recombine, scale, saturate
  always_comb begin
    tot      = (TW'(hi_sum_r) <<< 32) + TW'(lo_sum_r);
    top_bits = tot[TW-1:SH+DW-1];
    if ((top_bits == '0) || (top_bits == '1)) begin
      res_nxt = tot[SH+DW-1:SH];
    end else if (tot[TW-1]) begin
      res_nxt = pmiw_pkg::SAT_MIN;
    end else begin
      res_nxt = pmiw_pkg::SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_o = res_r;

endmodule

/* rtl/periodic_minimum_image_wrap.sv */
// ----------------------------------------------------------------------------
// periodic_minimum_image_wrap
// Triclinic-cell minimum-image displacement and position wrap, fixed point.
// ----------------------------------------------------------------------------
// Usage: the block takes one transaction per clock (start high while busy is
// low; busy is only high during reset) and returns each result on
// out_x/out_y/out_z with a single-cycle out_valid strobe.
// There is no backpressure on the result side, so the receiver must take
// every strobe. The pipeline has five stages: inverse-matrix
// products, fractional reduction, cell-matrix partial products (split over
// the high and low words of the fractional coordinate to keep multipliers
// narrow), partial sums, and recombine/round/saturate. Three lanes compute
// the fractional coordinates side by side; their outputs are merged into one
// vector that feeds three Cartesian lanes. Configuration registers (cell and
// inverse rows, periodic mask) are written through the cfg port, which is
// always ready; write them only while no transaction is in flight. Unknown
// register indexes are ignored.
// ----------------------------------------------------------------------------
module periodic_minimum_image_wrap #(
  parameter int POS_FRAC_BITS = pmiw_pkg::DEF_POS_FRAC_BITS,
  parameter int COEF_WIDTH    = pmiw_pkg::DEF_COEF_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_kind,
  input  logic signed [pmiw_pkg::DATA_W-1:0] in_x,
  input  logic signed [pmiw_pkg::DATA_W-1:0] in_y,
  input  logic signed [pmiw_pkg::DATA_W-1:0] in_z,
  // result channel
  output logic                              out_valid,
  output logic signed [pmiw_pkg::DATA_W-1:0] out_x,
  output logic signed [pmiw_pkg::DATA_W-1:0] out_y,
  output logic signed [pmiw_pkg::DATA_W-1:0] out_z,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pmiw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pmiw_pkg::ROW_W-1:0]        cfg_data
);

  localparam int NA        = pmiw_pkg::NUM_AXES;
  localparam int CELL_FRAC = COEF_WIDTH / 2;
  localparam int INV_FRAC  = COEF_WIDTH - 2;
  localparam int SW        = COEF_WIDTH + 34;
  localparam int LATENCY   = 5;
  localparam logic [pmiw_pkg::ROW_W-1:0] CELL_ONE = pmiw_pkg::ROW_W'(64'd1 << CELL_FRAC);
  localparam logic [pmiw_pkg::ROW_W-1:0] INV_ONE  = pmiw_pkg::ROW_W'(64'd1 << INV_FRAC);

  logic [pmiw_pkg::ROW_W-1:0]           cell_row_r [NA];
  logic [pmiw_pkg::ROW_W-1:0]           inv_row_r  [NA];
  logic [NA-1:0]                        mask_r;
  logic                                 busy_r;
  logic [LATENCY-1:0]                   vld_r;
  logic                                 accept;
  logic                                 cfg_we;
  logic [NA-1:0][pmiw_pkg::DATA_W-1:0]  pos_vec;
  logic [NA-1:0][SW-1:0]                frac_vec;   // merged fractional vector
  logic [NA-1:0][pmiw_pkg::DATA_W-1:0]  res_vec;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // busy only while held in reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // configuration registers; identity matrices and all-periodic after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NA; i++) begin
        cell_row_r[i] <= CELL_ONE << (i * COEF_WIDTH);
        inv_row_r[i]  <= INV_ONE << (i * COEF_WIDTH);
      end
      mask_r <= '1;
    end else if (cfg_we) begin
      unique case (pmiw_pkg::cfg_idx_t'(cfg_index))
        pmiw_pkg::REG_CELL_ROW0: cell_row_r[0] <= cfg_data;
        pmiw_pkg::REG_CELL_ROW1: cell_row_r[1] <= cfg_data;
        pmiw_pkg::REG_CELL_ROW2: cell_row_r[2] <= cfg_data;
        pmiw_pkg::REG_INV_ROW0:  inv_row_r[0]  <= cfg_data;
        pmiw_pkg::REG_INV_ROW1:  inv_row_r[1]  <= cfg_data;
        pmiw_pkg::REG_INV_ROW2:  inv_row_r[2]  <= cfg_data;
        pmiw_pkg::REG_PER_MASK:  mask_r        <= cfg_data[NA-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // transaction valid tracks the payload through the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LATENCY-2:0], accept};
    end
  end

  assign pos_vec = {in_z, in_y, in_x};

  // fractional-coordinate lanes, one per axis
  for (genvar i = 0; i < NA; i++) begin : g_frac
    pmiw_pkg::frac_ctl_t ctl;
    assign ctl.wrap     = in_kind;
    assign ctl.periodic = mask_r[i];

    pmiw_frac_lane #(
      .POS_FRAC_BITS (POS_FRAC_BITS),
      .COEF_WIDTH    (COEF_WIDTH)
    ) u_frac (
      .clk     (clk),
      .inv_row (inv_row_r[i]),
      .pos_i   (pos_vec),
      .ctl_i   (ctl),
      .frac_o  (frac_vec[i])
    );
  end

  // Cartesian lanes: each sees the whole merged fractional vector
  for (genvar i = 0; i < NA; i++) begin : g_cart
    pmiw_cart_lane #(
      .COEF_WIDTH (COEF_WIDTH)
    ) u_cart (
      .clk      (clk),
      .cell_row (cell_row_r[i]),
      .frac_i   (frac_vec),
      .res_o    (res_vec[i])
    );
  end

  assign out_valid = vld_r[LATENCY-1];
  assign out_x     = res_vec[0];
  assign out_y     = res_vec[1];
  assign out_z     = res_vec[2];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // every accepted transaction produces a strobe after the fixed latency
  a_accept_to_out : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_valid)
    else $error("accepted transaction produced no result");

  // no strobe without a matching accepted transaction
  a_out_from_accept : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result strobe without accepted transaction");

  // a mask write lands in the mask register
  a_mask_write : assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == pmiw_pkg::REG_PER_MASK))
      |=> (mask_r == $past(cfg_data[NA-1:0])))
    else $error("periodic mask write lost");

endmodule
